### design/b49enc_pkg.sv
// Shared constants and types for the base-49 text encoder.
`timescale 1ns / 1ps
`default_nettype none

package b49enc_pkg;

    // Bits in one group and the width of the pending bit store.
    localparam int GROUP_BITS = 28;
    localparam int ACC_BITS   = GROUP_BITS - 1;
    localparam int CNT_BITS   = 5;

    // Digits per group and the index of the final digit.
    localparam int          DIGITS     = 5;
    localparam int          DIG_BITS   = 3;
    localparam logic [2:0]  LAST_DIGIT = 3'(DIGITS - 1);

    // First printable character ('#').
    localparam logic [6:0] CHAR_BASE = 7'd35;

    // Division by 49 as a multiply by a rounded-up reciprocal. For any value below
    // 2**28 the error term (40) stays below 2**(34-28), so the quotient is exact.
    localparam int           RECIP_SHIFT = 34;
    localparam logic [28:0]  RECIP       = 29'd350609576;
    localparam int           QUOT_BITS   = 23;

    // Group queue depth and pointer width.
    localparam int GQ_DEPTH = 4;
    localparam int GQ_AW    = 2;
    localparam int GQ_CW    = 3;

    typedef struct packed {
        logic [GROUP_BITS-1:0] bits;
        logic                  last;
    } t_group;

    // Up to two groups produced by one input word, first in slot a.
    typedef struct packed {
        logic   push_a;
        logic   push_b;
        t_group grp_a;
        t_group grp_b;
    } t_push;

endpackage

`default_nettype wire

### design/b49enc_packer.sv
// Bit packer: gathers input bytes into 28-bit groups and flushes on the last byte.
`timescale 1ns / 1ps
`default_nettype none

module b49enc_packer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    output b49enc_pkg::t_push       o_push
);
    import b49enc_pkg::*;

    logic [ACC_BITS-1:0] r_acc;
    logic [CNT_BITS-1:0] r_cnt;
    logic [ACC_BITS-1:0] n_acc;
    logic [CNT_BITS-1:0] n_cnt;

    logic [34:0] wide;
    logic [5:0]  sum;
    logic        full;
    logic [5:0]  rem_cnt;
    logic [6:0]  rest;

    always_comb begin
        wide    = {8'd0, r_acc} | ({27'd0, i_data_byte} << r_cnt);
        sum     = {1'b0, r_cnt} + 6'd8;
        full    = (sum >= 6'(GROUP_BITS));
        rem_cnt = full ? (sum - 6'(GROUP_BITS)) : sum;
        rest    = wide[34:GROUP_BITS];

        o_push = '0;
        if (full) begin
            // A full group leaves; on the last byte any spill-over follows padded.
            o_push.push_a      = i_accept;
            o_push.grp_a.bits  = wide[GROUP_BITS-1:0];
            o_push.grp_a.last  = i_last_byte && (rem_cnt == 6'd0);
            o_push.push_b      = i_accept && i_last_byte && (rem_cnt != 6'd0);
            o_push.grp_b.bits  = {21'd0, rest};
            o_push.grp_b.last  = 1'b1;
        end else begin
            // The partial group always holds at least this byte.
            o_push.push_a      = i_accept && i_last_byte;
            o_push.grp_a.bits  = wide[GROUP_BITS-1:0];
            o_push.grp_a.last  = 1'b1;
        end

        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_accept) begin
            if (i_last_byte) begin
                n_acc = '0;
                n_cnt = '0;
            end else if (full) begin
                n_acc = {20'd0, rest};
                n_cnt = rem_cnt[CNT_BITS-1:0];
            end else begin
                n_acc = wide[ACC_BITS-1:0];
                n_cnt = sum[CNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### design/b49enc_group_fifo.sv
// Small queue of groups waiting for digit conversion; takes up to two per cycle.
`timescale 1ns / 1ps
`default_nettype none

module b49enc_group_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire b49enc_pkg::t_push  i_push,
    input  wire logic               i_pop,
    output b49enc_pkg::t_group      o_head,
    output logic                    o_not_empty,
    output logic                    o_has_room
);
    import b49enc_pkg::*;

    t_group             r_mem [GQ_DEPTH];
    logic [GQ_AW-1:0]   r_wr;
    logic [GQ_AW-1:0]   r_rd;
    logic [GQ_CW-1:0]   r_count;
    logic [GQ_AW-1:0]   wr_next;

    assign wr_next     = r_wr + GQ_AW'(1);
    assign o_head      = r_mem[r_rd];
    assign o_not_empty = (r_count != '0);
    // Room for the worst case of two groups from one word.
    assign o_has_room  = (r_count <= GQ_CW'(GQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr] <= i_push.grp_a;
        end
        if (i_push.push_b) begin
            r_mem[wr_next] <= i_push.grp_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + GQ_AW'(i_push.push_a) + GQ_AW'(i_push.push_b);
            r_rd    <= r_rd + GQ_AW'(i_pop);
            r_count <= r_count + GQ_CW'(i_push.push_a) + GQ_CW'(i_push.push_b)
                       - GQ_CW'(i_pop);
        end
    end

endmodule

`default_nettype wire

### design/b49enc_digit_unit.sv
// Digit unit: peels one base-49 digit per cycle off a group while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module b49enc_digit_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire b49enc_pkg::t_group i_head,
    input  wire logic               i_not_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [6:0]              o_out_char,
    output logic                    o_end_of_text
);
    import b49enc_pkg::*;

    logic                   r_busy;
    logic [GROUP_BITS-1:0]  r_val;
    logic [DIG_BITS-1:0]    r_dig;
    logic                   r_last;
    logic                   r_ovalid;
    logic [6:0]             r_char;
    logic                   r_eot;

    logic [56:0]            prod;
    logic [QUOT_BITS-1:0]   quot;
    logic [GROUP_BITS-1:0]  quot_x49;
    logic [GROUP_BITS-1:0]  diff;
    logic [5:0]             digit;
    logic                   adv;
    logic                   final_dig;

    always_comb begin
        prod     = {29'd0, r_val} * {28'd0, RECIP};
        quot     = prod[RECIP_SHIFT +: QUOT_BITS];
        quot_x49 = {quot, 5'd0} + {1'b0, quot, 4'd0} + {5'd0, quot};
        diff     = r_val - quot_x49;
        digit    = diff[5:0];
    end

    assign adv       = r_busy && (!r_ovalid || !i_stall);
    assign final_dig = (r_dig == LAST_DIGIT);
    assign o_pop     = i_not_empty && (!r_busy || (adv && final_dig));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && final_dig) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_val  <= i_head.bits;
            r_dig  <= '0;
            r_last <= i_head.last;
        end else if (adv) begin
            r_val  <= {5'd0, quot};
            r_dig  <= r_dig + DIG_BITS'(1);
        end
        if (adv) begin
            r_char <= CHAR_BASE + {1'b0, digit};
            r_eot  <= r_last && final_dig;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_char    = r_char;
    assign o_end_of_text = r_eot;

endmodule

`default_nettype wire

### design/base49_text_encoder.sv
// Top level of the base-49 text encoder: byte stream in, printable characters out.
// Path: a group whose last byte (or flushing byte) is accepted is written to the queue,
// loaded into the digit unit's value register once the unit is free, and each of its
// characters is registered in the output register. One character per cycle from a single
// digit unit while the output is not stalled; a group of five characters carries 3.5 bytes.
// A byte is taken whenever the queue has room for two groups.
// Reset is synchronous and active low; it empties the queue and the pending bits.
`timescale 1ns / 1ps
`default_nettype none

module base49_text_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input word channel.
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    // Output word channel.
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [6:0]      o_out_char,
    output logic            o_end_of_text
);
    import b49enc_pkg::*;

    t_push  push;
    t_group head;
    logic   not_empty;
    logic   has_room;
    logic   pop;
    logic   in_accept;

    // The stall only looks at queue occupancy, so it never waits on i_valid.
    assign o_stall   = !has_room;
    assign in_accept = i_valid && has_room;

    // The packer folds each byte into the pending bits and hands out
    // zero, one or two complete groups in the same cycle.
    b49enc_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    // The queue decouples bursty group production from the digit unit, which takes
    // the next group as it emits the last digit of the current one.
    b49enc_group_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_has_room  (has_room)
    );

    // The digit unit emits the least significant digit first and marks the
    // fifth digit of the final group as the end of the text.
    b49enc_digit_unit u_digit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_not_empty   (not_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

endmodule

`default_nettype wire

### tb/tb_base49_text_encoder.sv
// Self-checking testbench for the base-49 text encoder.
`timescale 1ns / 1ps

module tb_base49_text_encoder;

    import b49enc_pkg::*;

    // One expected character of the encoded text.
    typedef struct {
        logic [6:0] ch;
        logic       eot;
    } t_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_out_char;
    logic       o_end_of_text;

    // Characters the encoder still owes us, oldest first.
    t_char expected_chars[$];

    // Our own copy of the pending bits of the current stream.
    logic [ACC_BITS-1:0] pend_bits = '0;
    logic [CNT_BITS-1:0] pend_cnt = '0;

    // Idle and stall rates in percent, plus a forced hold-off on the output side.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_cycles = 0;

    int unsigned err_count = 0;

    base49_text_encoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_end_of_text(o_end_of_text)
    );

    // 4 ns clock, high and low for 2 ns each.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Split one 28-bit group into five base-49 digits, least significant first.
    // Only the fifth character of a group can carry the end-of-text flag.
    function automatic void queue_group(logic [GROUP_BITS-1:0] grp, logic ends_text);
        logic [GROUP_BITS-1:0] rest;
        logic [6:0]            digit;
        t_char                 entry;
        rest = grp;
        for (int d = 0; d < DIGITS; d++) begin
            digit = 7'(rest % 28'd49);
            rest  = rest / 28'd49;
            entry.ch  = CHAR_BASE + digit;
            entry.eot = ends_text && d == DIGITS - 1;
            expected_chars.insert(expected_chars.size(), entry);
        end
    endfunction

    // Fold one accepted byte into the pending bits and queue the characters it
    // releases: a full group when 28 bits are present, and on the last byte of a
    // stream a zero-padded group for whatever is left over.
    function automatic void encode_byte(logic [7:0] data, logic last);
        logic [GROUP_BITS+7:0] work;
        int unsigned           nbits;
        nbits = pend_cnt;
        work  = (GROUP_BITS + 8)'(pend_bits) | ((GROUP_BITS + 8)'(data) << nbits);
        nbits += 8;
        if (nbits >= GROUP_BITS) begin
            // A group that closes exactly on the last byte ends the text itself.
            queue_group(work[GROUP_BITS-1:0], last && nbits == GROUP_BITS);
            nbits -= GROUP_BITS;
            work = work >> GROUP_BITS;
        end
        if (last) begin
            if (nbits > 0) begin
                queue_group(work[GROUP_BITS-1:0], 1'b1);
            end
            // The next byte starts a fresh stream.
            pend_bits = '0;
            pend_cnt  = '0;
        end else begin
            pend_bits = work[ACC_BITS-1:0];
            pend_cnt  = CNT_BITS'(nbits);
        end
    endfunction

    // Mostly uniform bytes, with the two extremes mixed in more often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: pick_byte = 8'h00;
            1: pick_byte = 8'hFF;
            default: pick_byte = 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one word at the falling edge and hold it until the encoder takes it.
    // Valid stays high on return so that back-to-back words need no toggle; any
    // caller that stops sending lowers it through drain_output.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        encode_byte(data, last);
        @(negedge i_clk);
    endtask

    // The sender pauses until every expected character has come out.
    task automatic drain_output();
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Send a list of bytes as one stream, the final byte flagged as last.
    task automatic send_stream(input logic [7:0] bytes[$]);
        foreach (bytes[k]) begin
            send_byte(bytes[k], k == bytes.size() - 1);
        end
    endtask

    // Directed corners: all-zero and all-one single bytes, a stream of seven bytes
    // that closes a group exactly on its last byte (largest possible group), a
    // stream of four bytes that yields a full group plus a padded one, and a
    // stream right after a last byte to show the pending bits were cleared, then seven zeros.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_stream('{8'h00});
        send_stream('{8'hFF});
        send_stream('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_stream('{8'h01, 8'h80, 8'h55, 8'hAA});
        send_stream('{8'h7F});
        send_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        drain_output();
    endtask

    // Random streams with random content. About a quarter of them are forced to a multiple of
    // seven bytes long, so the exact-group ending shows up regularly.
    task automatic test_random_streams(input int unsigned n_bytes, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned sent;
        int unsigned len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(3) == 0) begin
                len = 7 * $urandom_range(1, 3);
            end else begin
                len = $urandom_range(1, 24);
            end
            for (int unsigned k = 1; k <= len; k++) begin
                send_byte(pick_byte(), k == len);
            end
            sent += len;
        end
        drain_output();
    endtask

    // The output side holds off for a long stretch while bytes keep coming, so
    // the group queue fills and the encoder has to stall its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 160;
        for (int unsigned k = 1; k <= 32; k++) begin
            send_byte(pick_byte(), k == 32);
        end
        drain_output();
    endtask

    // Output side: a forced hold-off takes priority, otherwise stall at random.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare every accepted character with the oldest one still expected.
    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual char %0d eot %0b",
                         $time, o_out_char, o_end_of_text);
                err_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $display("%0t: out_char mismatch, expected %0d, actual %0d",
                             $time, want.ch, o_out_char);
                    err_count++;
                end
                if (o_end_of_text !== want.eot) begin
                    $display("%0t: end_of_text mismatch, expected %0b, actual %0b",
                             $time, want.eot, o_end_of_text);
                    err_count++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        // Hold reset low, then release it on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_streams(85, 0, 0);
        test_random_streams(85, 77, 0);
        test_random_streams(85, 0, 77);
        test_random_streams(85, 27, 27);
        test_backpressure();

        // Leave room for a stray word after the last expected character.
        repeat (20) @(negedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/b49enc_pkg.sv
design/b49enc_packer.sv
design/b49enc_group_fifo.sv
design/b49enc_digit_unit.sv
design/base49_text_encoder.sv
tb/tb_base49_text_encoder.sv
